>>> sv/amsv_pkg.sv
package amsv_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int NUM_CLASSES  = 4;

    localparam int PTR_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int CNT_W   = FILL_W;
    localparam int LBL_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int SCORE_W = 16;
    localparam int WLEN_W  = 7;

    // APB register file: two registers, read as 32-bit words, at byte offsets 0 and 4
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_STABILIZE = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_WIN_LEN   = 1'b1;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd16;

    typedef logic [LBL_W-1:0] t_label;

    // Window command issued on each accepted beat
    typedef struct packed {
        logic              load;
        logic              push;
        t_label            raw;
        logic [FILL_W-1:0] len;
    } t_win_cmd;

endpackage

>>> sv/argmax_sliding_majority_vote.sv
// Argmax classifier with sliding-window majority vote. Each input beat carries four
// signed Q8.8 class scores; each output beat carries the raw argmax label (lowest
// index wins ties) and the output label, which is the most frequent label among the
// last window_length raw labels when stabilize_enable is set, else the raw label.
// Throughput is one beat per clock while the sink does not stall. Stage 1 registers
// the label ring memory read of the oldest entry; the output register then takes the
// class count update and vote and holds the result while the sink stalls.
// window_length 0 acts as 1 and values above 64 act as 64. Registers: offset 0x0
// stabilize_enable (bit 0, reset 1), offset 0x4 window_length (bits 6:0, reset 16);
// write them only while no beat is in flight.
module argmax_sliding_majority_vote (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [amsv_pkg::ADDR_W-1:0]          paddr,
    input  logic [amsv_pkg::DATA_W-1:0]          pwdata,
    output logic [amsv_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [amsv_pkg::SCORE_W-1:0]  i_score_zero,
    input  logic signed [amsv_pkg::SCORE_W-1:0]  i_score_one,
    input  logic signed [amsv_pkg::SCORE_W-1:0]  i_score_two,
    input  logic signed [amsv_pkg::SCORE_W-1:0]  i_score_three,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output amsv_pkg::t_label                     o_label,
    output amsv_pkg::t_label                     o_raw_label
);
    import amsv_pkg::*;

    logic                  r_stab;
    logic [WLEN_W-1:0]     r_wlen;
    logic [FILL_W-1:0]     eff_len;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  cfg_wr;

    logic signed [SCORE_W-1:0] best01, best23;
    t_label                idx01, idx23, raw_label;

    logic                  accept;
    logic                  s1_adv;
    logic                  r_s1_valid;
    logic                  r_s1_stab;
    t_label                r_s1_raw;
    t_label                major;
    t_win_cmd              win_cmd;

    logic                  r_o_valid;
    logic                  r_o_stab;
    t_label                r_o_label;
    t_label                r_o_raw;

    // Configuration
    assign reg_idx = paddr[2 +: REG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stab <= 1'b1;
            r_wlen <= WLEN_RESET;
        end else if (cfg_wr) begin
            if (reg_idx == REG_STABILIZE) begin
                r_stab <= pwdata[0];
            end
            if (reg_idx == REG_WIN_LEN) begin
                r_wlen <= pwdata[WLEN_W-1:0];
            end
        end
    end

    always_comb begin
        case (reg_idx)
            REG_STABILIZE: prdata = DATA_W'(r_stab);
            REG_WIN_LEN:   prdata = DATA_W'(r_wlen);
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        if (r_wlen == '0) begin
            eff_len = FILL_W'(1);
        end else if (32'(r_wlen) > WINDOW_DEPTH) begin
            eff_len = FILL_W'(WINDOW_DEPTH);
        end else begin
            eff_len = FILL_W'(r_wlen);
        end
    end

    // Pairwise argmax; the later pair wins only when strictly greater
    always_comb begin
        if (i_score_one > i_score_zero) begin
            best01 = i_score_one;
            idx01  = LBL_W'(1);
        end else begin
            best01 = i_score_zero;
            idx01  = LBL_W'(0);
        end
        if (i_score_three > i_score_two) begin
            best23 = i_score_three;
            idx23  = LBL_W'(3);
        end else begin
            best23 = i_score_two;
            idx23  = LBL_W'(2);
        end
        raw_label = (best23 > best01) ? idx23 : idx01;
    end

    // Handshake: stage 1 advances into the output register when it is free or drains
    assign s1_adv  = r_s1_valid && (!r_o_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_adv;
    assign accept  = i_valid && o_ready;

    assign win_cmd.load = accept;
    assign win_cmd.push = r_stab;
    assign win_cmd.raw  = raw_label;
    assign win_cmd.len  = eff_len;

    amsv_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (win_cmd),
        .i_adv   (s1_adv),
        .o_major (major)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_raw  <= raw_label;
            r_s1_stab <= r_stab;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_label <= r_s1_stab ? major : r_s1_raw;
            r_o_raw   <= r_s1_raw;
            r_o_stab  <= r_s1_stab;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_label     = r_o_label;
    assign o_raw_label = r_o_raw;

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_o_valid |-> o_ready)
        else $error("input stalled while output register empty");

    a_raw_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_o_stab |-> o_label == o_raw_label)
        else $error("label differs from raw label with stabilizing off");

    a_out_from_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_s1_valid))
        else $error("output beat without a stage 1 item");

endmodule

>>> sv/amsv_window.sv
module amsv_window (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  amsv_pkg::t_win_cmd i_cmd,
    input  logic               i_adv,
    output amsv_pkg::t_label   o_major
);
    import amsv_pkg::*;

    logic [LBL_W-1:0]  r_ring [WINDOW_DEPTH];
    t_label            r_evict_lbl;

    logic [PTR_W-1:0]  r_oldest, n_oldest;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              evict;

    logic              r_s1_push;
    logic              r_s1_evict;
    t_label            r_s1_raw;

    logic [CNT_W-1:0]  r_counts [NUM_CLASSES];
    logic [CNT_W-1:0]  n_counts [NUM_CLASSES];
    logic [CNT_W-1:0]  top;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (32'(p) == WINDOW_DEPTH - 1) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    // Window full for the current length: the oldest label leaves first
    assign evict = i_cmd.push && (r_fill >= i_cmd.len) && (r_fill != '0);

    // Head is always oldest + fill, so the new label lands there either way
    always_comb begin
        n_oldest = r_oldest;
        n_head   = r_head;
        n_fill   = r_fill;
        if (i_cmd.load && i_cmd.push) begin
            n_head = ptr_inc(r_head);
            if (evict) begin
                n_oldest = ptr_inc(r_oldest);
            end else begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest   <= '0;
            r_head     <= '0;
            r_fill     <= '0;
            r_s1_push  <= 1'b0;
            r_s1_evict <= 1'b0;
        end else begin
            r_oldest <= n_oldest;
            r_head   <= n_head;
            r_fill   <= n_fill;
            if (i_cmd.load) begin
                r_s1_push  <= i_cmd.push;
                r_s1_evict <= evict;
            end
        end
    end

    // Read-before-write: each load reads the oldest label, the one a full window evicts
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_evict_lbl <= r_ring[r_oldest];
            r_s1_raw    <= i_cmd.raw;
        end
        if (i_cmd.load && i_cmd.push) begin
            r_ring[r_head] <= i_cmd.raw;
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            n_counts[c] = r_counts[c];
            if (r_s1_push) begin
                if (r_s1_evict && r_evict_lbl == LBL_W'(c) && r_counts[c] != '0) begin
                    n_counts[c] = n_counts[c] - 1'b1;
                end
                if (r_s1_raw == LBL_W'(c)) begin
                    n_counts[c] = n_counts[c] + 1'b1;
                end
            end
        end
    end

    // Strict compare keeps the lowest index on ties
    always_comb begin
        top     = '0;
        o_major = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (n_counts[c] > top) begin
                top     = n_counts[c];
                o_major = LBL_W'(c);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_counts[c] <= '0;
            end
        end else if (i_adv) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_counts[c] <= n_counts[c];
            end
        end
    end

endmodule
